@@ design/tlcs_pkg.sv @@
// ============================================================================
// tlcs_pkg: shared types and constants for the line centre steering block
// Payload structs, register map, frame geometry and pulse law constants.
// ============================================================================
package tlcs_pkg;

   // Frame geometry
   localparam int IMAGE_WIDTH = 188;

   localparam logic [7:0] HALF_WIDTH = 8'(IMAGE_WIDTH / 2);
   localparam logic [7:0] SCAN_FIRST = 8'd1;
   localparam logic [7:0] SCAN_LAST  = 8'(IMAGE_WIDTH - 2);
   localparam logic [7:0] LAST_COL   = 8'(IMAGE_WIDTH - 1);
   localparam logic [7:0] FAR_EDGE   = 8'(IMAGE_WIDTH - 11);
   localparam logic [7:0] NEAR_EDGE  = 8'd10;
   localparam logic [7:0] EDGE_NONE  = 8'd255;
   localparam logic [7:0] COUNT_MIN  = 8'd3;
   localparam logic [7:0] COUNT_MAX  = 8'd10;
   localparam logic [7:0] COUNT_SAT  = 8'd255;

   // Pulse law: base pulse width with four fraction bits
   localparam logic signed [19:0] BASE_PULSE_SCALED = 20'sd24000;

   // Number of scanned rows
   localparam int NUM_ROWS = 3;

   // Register map (word index)
   localparam logic [2:0] REG_P_GAIN     = 3'd0;
   localparam logic [2:0] REG_D_GAIN     = 3'd1;
   localparam logic [2:0] REG_UPPER_ROW  = 3'd2;
   localparam logic [2:0] REG_MIDDLE_ROW = 3'd3;
   localparam logic [2:0] REG_LOWER_ROW  = 3'd4;

   // Centre source codes
   localparam logic [1:0] SRC_UPPER  = 2'd0;
   localparam logic [1:0] SRC_MIDDLE = 2'd1;
   localparam logic [1:0] SRC_LOWER  = 2'd2;
   localparam logic [1:0] SRC_HELD   = 2'd3;

   typedef struct packed {
      logic [7:0] pixel_value;
      logic [5:0] row_index;
      logic [7:0] column_index;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [15:0] pulse_width;
      logic [7:0]  line_center;
      logic [1:0]  center_source;
      logic [7:0]  upper_black_count;
      logic [7:0]  middle_black_count;
      logic [7:0]  lower_black_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0]                 p_gain;
      logic [7:0]                 d_gain;
      logic [NUM_ROWS-1:0][5:0]   row_sel;
   } cfg_type;

   // Per-row statistics gathered over one frame
   typedef struct packed {
      logic [NUM_ROWS-1:0][7:0] count;
      logic [NUM_ROWS-1:0][7:0] left;
      logic [NUM_ROWS-1:0][7:0] right;
   } row_stats_type;

   // Chosen centre with the PD operands
   typedef struct packed {
      logic [7:0]               center;
      logic [1:0]               source;
      logic [NUM_ROWS-1:0][7:0] count;
      logic signed [9:0]        err;
      logic signed [8:0]        delta;
   } ctr_type;

endpackage

@@ design/three_row_line_center_steering.sv @@
// ============================================================================
// three_row_line_center_steering: line centre and steering pulse from a frame
// Scans three configured rows of a binarised raster frame for black runs,
// picks a line centre at frame end and turns it into a steering pulse width.
// ============================================================================
//
//   channel | ports       | moves                               | handshake
//   --------+-------------+-------------------------------------+-------------------
//   req     | req_*       | one pixel (req_type)                | valid / stall
//   rsp     | rsp_*       | one frame result (rsp_type)         | valid / stall
//   csr     | csr_*       | gains and row selections            | APB-style, no wait
//
// One pixel transaction is taken every cycle unless a held frame end pixel
// stalls the input. A frame end pixel's result transaction passes the input
// register, statistics snapshot, centre register and result register. A waiting
// result stalls only later frame end pixels, and only once the snapshot and
// centre slots are full; ordinary pixels keep flowing until such a pixel is held.
// Synchronous reset clears the row statistics, the run tracker, the held centre
// and every valid flag and loads the register defaults; no clearing pass is needed.
//
module three_row_line_center_steering
   import tlcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // pixel input
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   // frame result
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type       cfg;
   logic          snap_valid;
   logic          snap_stall;
   row_stats_type snap;
   logic          ctr_valid;
   logic          ctr_stall;
   ctr_type       ctr;

   // Register file: gains and the three row selections
   tlcs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Count black pixels and record run starts; snapshot and clear at frame end
   tlcs_row_track u_row_track (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg),
      .snap_valid  (snap_valid),
      .snap_stall  (snap_stall),
      .snap        (snap)
   );

   // Pick the first usable row centre, else hold the last one
   tlcs_center u_center (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap_stall (snap_stall),
      .snap       (snap),
      .ctr_valid  (ctr_valid),
      .ctr_stall  (ctr_stall),
      .ctr        (ctr)
   );

   // Apply the PD law and hold the result transaction until taken
   tlcs_pd u_pd (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .ctr_valid   (ctr_valid),
      .ctr_stall   (ctr_stall),
      .ctr         (ctr),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ design/tlcs_csr.sv @@
// ============================================================================
// tlcs_csr: configuration registers
// Gains and row selections behind a simple APB-style port.
// ============================================================================
module tlcs_csr
   import tlcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign reg_index  = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_P_GAIN:     cfg_in.p_gain     = csr_pwdata[7:0];
            REG_D_GAIN:     cfg_in.d_gain     = csr_pwdata[7:0];
            REG_UPPER_ROW:  cfg_in.row_sel[0] = csr_pwdata[5:0];
            REG_MIDDLE_ROW: cfg_in.row_sel[1] = csr_pwdata[5:0];
            REG_LOWER_ROW:  cfg_in.row_sel[2] = csr_pwdata[5:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.p_gain     <= 8'd96;
         cfg_ff.d_gain     <= 8'd224;
         cfg_ff.row_sel[0] <= 6'd5;
         cfg_ff.row_sel[1] <= 6'd20;
         cfg_ff.row_sel[2] <= 6'd35;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_P_GAIN:     csr_prdata = {24'd0, cfg_ff.p_gain};
         REG_D_GAIN:     csr_prdata = {24'd0, cfg_ff.d_gain};
         REG_UPPER_ROW:  csr_prdata = {26'd0, cfg_ff.row_sel[0]};
         REG_MIDDLE_ROW: csr_prdata = {26'd0, cfg_ff.row_sel[1]};
         REG_LOWER_ROW:  csr_prdata = {26'd0, cfg_ff.row_sel[2]};
         default:        csr_prdata = 32'd0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ design/tlcs_row_track.sv @@
// ============================================================================
// tlcs_row_track: per-row black pixel statistics
// Registers each pixel, updates counts and run-start edges, snapshots on frame end.
// ============================================================================
module tlcs_row_track
   import tlcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_payload,
   input  cfg_type       cfg,
   output logic          snap_valid,
   input  logic          snap_stall,
   output row_stats_type snap
);

   logic          in_valid_ff;
   logic          in_valid_in;
   req_type       in_ff;
   row_stats_type stats_ff;
   row_stats_type stats_in;
   row_stats_type stats_next;
   logic          prev_black_ff;
   logic          prev_black_in;
   logic          snap_valid_ff;
   logic          snap_valid_in;
   row_stats_type snap_ff;
   logic          hold;
   logic          retire;
   logic          take_snap;
   logic          black;
   logic          in_scan;
   logic          hit;

   // A frame end item waits only when the snapshot slot is still occupied and stalled
   assign hold      = in_valid_ff && in_ff.frame_end && snap_valid_ff && snap_stall;
   assign retire    = in_valid_ff && !hold;
   assign take_snap = retire && in_ff.frame_end;
   assign req_stall = hold;

   assign black   = (in_ff.pixel_value == 8'd0);
   assign in_scan = (in_ff.column_index >= SCAN_FIRST) && (in_ff.column_index <= SCAN_LAST);

   always_comb begin
      stats_next = stats_ff;
      hit        = 1'b0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         hit = in_scan && black && (in_ff.row_index == cfg.row_sel[r]);
         if (hit) begin
            if (stats_ff.count[r] != COUNT_SAT) begin
               stats_next.count[r] = stats_ff.count[r] + 8'd1;
            end
            if (!prev_black_ff) begin
               if (stats_ff.left[r] == EDGE_NONE) begin
                  stats_next.left[r] = in_ff.column_index;
               end else begin
                  stats_next.right[r] = in_ff.column_index;
               end
            end
         end
      end
   end

   always_comb begin
      stats_in      = stats_ff;
      prev_black_in = prev_black_ff;
      if (retire) begin
         prev_black_in = black;
         if (in_ff.frame_end) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
               stats_in.count[r] = 8'd0;
               stats_in.left[r]  = EDGE_NONE;
               stats_in.right[r] = EDGE_NONE;
            end
         end else begin
            stats_in = stats_next;
         end
      end
      in_valid_in = hold ? 1'b1 : req_valid;
      priority if (take_snap) begin
         snap_valid_in = 1'b1;
      end else if (!snap_stall) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         prev_black_ff <= 1'b0;
         snap_valid_ff <= 1'b0;
         for (int r = 0; r < NUM_ROWS; r++) begin
            stats_ff.count[r] <= 8'd0;
            stats_ff.left[r]  <= EDGE_NONE;
            stats_ff.right[r] <= EDGE_NONE;
         end
      end else begin
         in_valid_ff   <= in_valid_in;
         prev_black_ff <= prev_black_in;
         snap_valid_ff <= snap_valid_in;
         stats_ff      <= stats_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_payload;
      end
      if (take_snap) begin
         snap_ff <= stats_next;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

@@ design/tlcs_center.sv @@
// ============================================================================
// tlcs_center: line centre selection
// Picks the first usable row centre, holds the last centre, forms PD operands.
// ============================================================================
module tlcs_center
   import tlcs_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          snap_valid,
   output logic          snap_stall,
   input  row_stats_type snap,
   output logic          ctr_valid,
   input  logic          ctr_stall,
   output ctr_type       ctr
);

   logic                 ctr_valid_ff;
   logic                 ctr_valid_in;
   ctr_type              ctr_ff;
   ctr_type              ctr_in;
   logic [7:0]           last_center_ff;
   logic                 load;
   logic [NUM_ROWS-1:0]  row_ok;
   logic [NUM_ROWS-1:0][7:0] row_ctr;

   function automatic logic [7:0] row_center(input logic [7:0] l, input logic [7:0] r);
      logic [8:0] sum_both;
      logic [8:0] sum_far;
      logic [7:0] c;
      sum_both = {1'b0, l} + {1'b0, r};
      sum_far  = {1'b0, l} + 9'(IMAGE_WIDTH);
      priority if (r != EDGE_NONE) begin
         c = sum_both[8:1];
      end else if (l < HALF_WIDTH) begin
         c = (l < NEAR_EDGE) ? 8'd0 : {1'b0, l[7:1]};
      end else if (l > FAR_EDGE) begin
         c = LAST_COL;
      end else begin
         c = sum_far[8:1];
      end
      return c;
   endfunction

   assign snap_stall = ctr_valid_ff && ctr_stall;
   assign load       = snap_valid && !snap_stall;

   always_comb begin
      for (int r = 0; r < NUM_ROWS; r++) begin
         row_ok[r]  = (snap.count[r] >= COUNT_MIN) && (snap.count[r] <= COUNT_MAX);
         row_ctr[r] = row_center(snap.left[r], snap.right[r]);
      end
      ctr_in.count = snap.count;
      priority if (row_ok[0]) begin
         ctr_in.center = row_ctr[0];
         ctr_in.source = SRC_UPPER;
      end else if (row_ok[1]) begin
         ctr_in.center = row_ctr[1];
         ctr_in.source = SRC_MIDDLE;
      end else if (row_ok[2]) begin
         ctr_in.center = row_ctr[2];
         ctr_in.source = SRC_LOWER;
      end else begin
         ctr_in.center = last_center_ff;
         ctr_in.source = SRC_HELD;
      end
      ctr_in.err   = $signed({2'b00, HALF_WIDTH}) - $signed({2'b00, ctr_in.center});
      ctr_in.delta = $signed({1'b0, last_center_ff}) - $signed({1'b0, ctr_in.center});
      priority if (load) begin
         ctr_valid_in = 1'b1;
      end else if (!ctr_stall) begin
         ctr_valid_in = 1'b0;
      end else begin
         ctr_valid_in = ctr_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_valid_ff   <= 1'b0;
         last_center_ff <= 8'd0;
      end else begin
         ctr_valid_ff <= ctr_valid_in;
         if (load) begin
            last_center_ff <= ctr_in.center;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ctr_ff <= ctr_in;
      end
   end

   assign ctr_valid = ctr_valid_ff;
   assign ctr       = ctr_ff;

endmodule

@@ design/tlcs_pd.sv @@
// ============================================================================
// tlcs_pd: steering pulse law
// Applies the PD law in fixed point and holds the result transaction.
// ============================================================================
module tlcs_pd
   import tlcs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    ctr_valid,
   output logic    ctr_stall,
   input  ctr_type ctr,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               load;
   logic signed [18:0] p_term;
   logic signed [17:0] d_term;
   logic signed [19:0] sum;

   assign ctr_stall = rsp_valid_ff && rsp_stall;
   assign load      = ctr_valid && !ctr_stall;

   assign p_term = $signed({1'b0, cfg.p_gain}) * ctr.err;
   assign d_term = $signed({1'b0, cfg.d_gain}) * ctr.delta;
   assign sum    = BASE_PULSE_SCALED + 20'(p_term) + 20'(d_term);

   always_comb begin
      // The sum stays below 2^19, so only the lower clamp can bite
      rsp_in.pulse_width        = sum[19] ? 16'd0 : sum[19:4];
      rsp_in.line_center        = ctr.center;
      rsp_in.center_source      = ctr.source;
      rsp_in.upper_black_count  = ctr.count[0];
      rsp_in.middle_black_count = ctr.count[1];
      rsp_in.lower_black_count  = ctr.count[2];
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
